// ===== design/gte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gte_pkg;

  // Field widths fixed by the item format
  localparam int VERTEX_W     = 4;
  localparam int KIND_W       = 2;
  // Highest vertex number the 4-bit fields can name, plus one
  localparam int FIELD_SPAN   = 16;
  localparam int DEF_VERTICES = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_START = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DFS_STEP,
    ST_BFS_POP,
    ST_BFS_SCAN,
    ST_FLUSH_LAST
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear_graph;
    logic add_edge;
    logic start_walk;
    logic dfs_push;
    logic dfs_pop;
    logic bfs_pop;
    logic bfs_enq;
    logic flush_last;
  } gte_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic walk_mode;
    logic from_ok;
    logic mask_any;
    logic emit_ok;
    logic out_free;
    logic stack_one;
    logic queue_empty;
  } gte_status_t;

endpackage : gte_pkg

`default_nettype wire

// ===== design/gte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command channel: clear, add edge, start walk
interface gte_in_if;
  logic                         valid;
  logic                         ready;
  logic [gte_pkg::KIND_W-1:0]   kind;
  logic [gte_pkg::VERTEX_W-1:0] from_vertex;
  logic [gte_pkg::VERTEX_W-1:0] to_vertex;

  modport source (output valid, output kind, output from_vertex, output to_vertex,
                  input ready);
  modport sink   (input valid, input kind, input from_vertex, input to_vertex,
                  output ready);
endinterface : gte_in_if

// Result channel: one visited vertex per transaction
interface gte_out_if;
  logic                         valid;
  logic                         ready;
  logic [gte_pkg::VERTEX_W-1:0] vertex;
  logic                         last;

  modport source (output valid, output vertex, output last, input ready);
  modport sink   (input valid, input vertex, input last, output ready);
endinterface : gte_out_if

`default_nettype wire

// ===== design/gte_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gte_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [gte_pkg::KIND_W-1:0]  in_kind_i,
  output logic                             in_ready_o,
  input  wire gte_pkg::gte_status_t        status_i,
  output gte_pkg::gte_cmd_t                cmd_o
);
  import gte_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (kind_e'(in_kind_i))
            KIND_CLEAR: cmd_o.clear_graph = 1'b1;
            KIND_ADD:   cmd_o.add_edge    = 1'b1;
            KIND_START: begin
              if (status_i.from_ok) begin
                cmd_o.start_walk = 1'b1;
                state_d = status_i.walk_mode ? ST_BFS_POP : ST_DFS_STEP;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DFS_STEP: begin
        // Descend to the lowest unvisited neighbor, or backtrack
        if (status_i.mask_any) begin
          if (status_i.emit_ok) cmd_o.dfs_push = 1'b1;
        end else begin
          cmd_o.dfs_pop = 1'b1;
          if (status_i.stack_one) state_d = ST_FLUSH_LAST;
        end
      end
      ST_BFS_POP: begin
        if (status_i.queue_empty) begin
          state_d = ST_FLUSH_LAST;
        end else if (status_i.emit_ok) begin
          cmd_o.bfs_pop = 1'b1;
          state_d = ST_BFS_SCAN;
        end
      end
      ST_BFS_SCAN: begin
        // Enqueue one unvisited neighbor per cycle
        if (status_i.mask_any) begin
          cmd_o.bfs_enq = 1'b1;
        end else begin
          state_d = ST_BFS_POP;
        end
      end
      ST_FLUSH_LAST: begin
        if (status_i.out_free) begin
          cmd_o.flush_last = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule : gte_ctrl

`default_nettype wire

// ===== design/gte_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gte_datapath #(
  parameter int VERTICES = gte_pkg::DEF_VERTICES
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          mode_we_i,
  input  wire logic                          mode_i,
  input  wire logic [gte_pkg::VERTEX_W-1:0]  from_vertex_i,
  input  wire logic [gte_pkg::VERTEX_W-1:0]  to_vertex_i,
  input  wire gte_pkg::gte_cmd_t             cmd_i,
  output gte_pkg::gte_status_t               status_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [gte_pkg::VERTEX_W-1:0]       out_vertex_o,
  output logic                               out_last_o
);
  import gte_pkg::*;

  // Only vertices the 4-bit fields can name ever hold edges
  localparam int NV = (VERTICES < FIELD_SPAN) ? VERTICES : FIELD_SPAN;
  localparam int IW = $clog2(NV);
  localparam int PW = $clog2(NV + 1);
  localparam logic [VERTEX_W-1:0] VMAX = VERTEX_W'(NV - 1);

  logic [NV-1:0]       rows_q [NV];
  logic [NV-1:0]       visited_q;
  logic [VERTEX_W-1:0] store_q [NV];
  logic [PW-1:0]       wr_ptr_q, head_q;
  logic [VERTEX_W-1:0] cur_q, held_q;
  logic                held_valid_q;
  logic                mode_q;
  logic                out_valid_q, out_last_q;
  logic [VERTEX_W-1:0] out_vertex_q;

  logic                from_ok, to_ok, out_free;
  logic [PW-1:0]       rd_ptr;
  logic [VERTEX_W-1:0] rd_data, scan_v, next_v;
  logic [NV-1:0]       mask;

  assign from_ok = (from_vertex_i <= VMAX);
  assign to_ok   = (to_vertex_i <= VMAX);
  assign out_free = !out_valid_q || out_ready_i;

  // Depth-first reads the stack top, breadth-first reads the queue head
  assign rd_ptr  = mode_q ? head_q : (wr_ptr_q - PW'(1));
  assign rd_data = store_q[rd_ptr[IW-1:0]];
  assign scan_v  = mode_q ? cur_q : rd_data;
  assign mask    = rows_q[scan_v[IW-1:0]] & ~visited_q;

  // Pick the lowest unvisited neighbor
  always_comb begin
    next_v = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (mask[i]) next_v = VERTEX_W'(i);
    end
  end

  always_comb begin
    status_o             = '0;
    status_o.walk_mode   = mode_q;
    status_o.from_ok     = from_ok;
    status_o.mask_any    = |mask;
    status_o.emit_ok     = !held_valid_q || out_free;
    status_o.out_free    = out_free;
    status_o.stack_one   = (wr_ptr_q == PW'(1));
    status_o.queue_empty = (head_q == wr_ptr_q);
  end

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (mode_we_i) begin
      mode_q <= mode_i;
    end
  end

  // Adjacency matrix and visited marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NV; r++) rows_q[r] <= '0;
      visited_q <= '0;
    end else begin
      if (cmd_i.clear_graph) begin
        for (int r = 0; r < NV; r++) rows_q[r] <= '0;
      end
      if (cmd_i.add_edge && from_ok && to_ok) begin
        rows_q[from_vertex_i[IW-1:0]][to_vertex_i[IW-1:0]] <= 1'b1;
      end
      if (cmd_i.start_walk) begin
        visited_q <= '0;
        visited_q[from_vertex_i[IW-1:0]] <= 1'b1;
      end
      if (cmd_i.dfs_push || cmd_i.bfs_enq) begin
        visited_q[next_v[IW-1:0]] <= 1'b1;
      end
    end
  end

  // Stack / queue storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_walk) begin
      store_q[0] <= from_vertex_i;
    end else if (cmd_i.dfs_push || cmd_i.bfs_enq) begin
      store_q[wr_ptr_q[IW-1:0]] <= next_v;
    end
  end

  // Pointers and walk control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      head_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.start_walk) begin
        wr_ptr_q     <= PW'(1);
        head_q       <= '0;
        held_valid_q <= !mode_q;
      end
      if (cmd_i.dfs_push || cmd_i.bfs_enq) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (cmd_i.dfs_pop) wr_ptr_q <= wr_ptr_q - PW'(1);
      if (cmd_i.bfs_pop) head_q <= head_q + PW'(1);
      if (cmd_i.dfs_push || cmd_i.bfs_pop) begin
        held_valid_q <= 1'b1;
        if (held_valid_q) out_valid_q <= 1'b1;
      end
      if (cmd_i.flush_last) begin
        held_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end
    end
  end

  // Held vertex and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_walk) held_q <= from_vertex_i;
    if (cmd_i.dfs_push) held_q <= next_v;
    if (cmd_i.bfs_pop) begin
      held_q <= rd_data;
      cur_q  <= rd_data;
    end
    if ((cmd_i.dfs_push || cmd_i.bfs_pop) && held_valid_q) begin
      out_vertex_q <= held_q;
      out_last_q   <= 1'b0;
    end
    if (cmd_i.flush_last) begin
      out_vertex_q <= held_q;
      out_last_q   <= 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_vertex_o = out_vertex_q;
  assign out_last_o   = out_last_q;

endmodule : gte_datapath

`default_nettype wire

// ===== design/graph_traversal_engine_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake      Payload
// in_i       in   valid/ready    kind, from_vertex, to_vertex
// out_o      out  valid/ready    vertex, last
// walk_mode  in   write enable   walk_mode_i (0 depth-first, 1 breadth-first)
//
// Clear and add-edge are done as they are accepted. A depth-first walk steps
// through the accept, a descent per new vertex, a backtrack per vertex and
// the flush; a breadth-first walk through the accept, a dequeue per vertex,
// an enqueue per neighbor, a row scan end, the empty-queue check and flush.
// Reset clears the matrix, marks and mode at once. A stalled result holds
// the walk where it next emits a vertex; a new command is taken only once the walk is finished.

module graph_traversal_engine_top #(
  parameter int VERTICES = gte_pkg::DEF_VERTICES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gte_in_if.sink    in_i,
  gte_out_if.source out_o,
  input  wire logic walk_mode_we_i,
  input  wire logic walk_mode_i
);
  import gte_pkg::*;

  gte_cmd_t    cmd;
  gte_status_t status;

  gte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gte_datapath #(
    .VERTICES (VERTICES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mode_we_i     (walk_mode_we_i),
    .mode_i        (walk_mode_i),
    .from_vertex_i (in_i.from_vertex),
    .to_vertex_i   (in_i.to_vertex),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_vertex_o  (out_o.vertex),
    .out_last_o    (out_o.last)
  );

endmodule : graph_traversal_engine_top

`default_nettype wire

// ===== tb/gte_tb_pkg.sv =====
`timescale 1ns / 1ps

package gte_tb_pkg;

  // walk_mode register values
  localparam logic MODE_DEPTH   = 1'b0;
  localparam logic MODE_BREADTH = 1'b1;

  // Command code the block ignores
  localparam logic [gte_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Most vertices one walk reports
  localparam int MAX_VISITS = 16;

endpackage : gte_tb_pkg

// ===== tb/gte_checker.sv =====
`timescale 1ns / 1ps

// Watch both channels, model the adjacency matrix and the walk order,
// and compare every accepted visit with the oldest predicted one.
module gte_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gte_in_if    in_w,
  gte_out_if   out_w,
  input  logic walk_mode_we_i,
  input  logic walk_mode_i,
  output int   mismatch_count,
  output int   pending_count,
  output int   walk_count,
  output int   vertex_count
);
  import gte_pkg::*;
  import gte_tb_pkg::*;

  localparam int NV = gte_pkg::DEF_VERTICES;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } visit_t;

  logic [NV-1:0] adj_rows [NV];
  logic [NV-1:0] reached;
  logic          walk_mode_q;
  visit_t        expected_visits [$];
  visit_t        want;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    walk_count     = 0;
    vertex_count   = 0;
  end

  // Work out the visiting order from start and queue one visit per vertex
  task automatic predict_walk(input logic [VERTEX_W-1:0] start);
    logic [VERTEX_W-1:0] order [MAX_VISITS];
    logic [VERTEX_W-1:0] pend [NV];
    int                  cursor [NV];
    int                  count;
    int                  depth;
    int                  head;
    int                  tail;
    int                  j;
    logic [VERTEX_W-1:0] v;
    visit_t              item;
    reached = '0;
    count   = 0;
    if (walk_mode_q == MODE_BREADTH) begin
      // Mark on enqueue, emit on dequeue
      head = 0;
      tail = 0;
      reached[start] = 1'b1;
      pend[tail] = start;
      tail++;
      while (head < tail && count < MAX_VISITS) begin
        v = pend[head];
        head++;
        order[count] = v;
        count++;
        for (j = 0; j < NV; j++) begin
          if (adj_rows[v][j] && !reached[j] && tail < NV) begin
            reached[j] = 1'b1;
            pend[tail] = j[VERTEX_W-1:0];
            tail++;
          end
        end
      end
    end else begin
      // Descend into the lowest unvisited neighbor, backtrack when none is left
      reached[start] = 1'b1;
      order[0]  = start;
      count     = 1;
      pend[0]   = start;
      cursor[0] = 0;
      depth     = 1;
      while (depth > 0 && count < MAX_VISITS) begin
        v = pend[depth-1];
        j = cursor[depth-1];
        while (j < NV && !(adj_rows[v][j] && !reached[j])) j++;
        if (j >= NV) begin
          depth--;
        end else begin
          cursor[depth-1] = j + 1;
          reached[j]      = 1'b1;
          order[count]    = j[VERTEX_W-1:0];
          count++;
          pend[depth]   = j[VERTEX_W-1:0];
          cursor[depth] = 0;
          depth++;
        end
      end
    end
    for (int k = 0; k < count; k++) begin
      item.vertex = order[k];
      item.last   = (k == count - 1);
      expected_visits.push_back(item);
    end
  endtask

  // Track the model on every accepted transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NV; r++) adj_rows[r] = '0;
      reached     = '0;
      walk_mode_q = MODE_DEPTH;
      expected_visits.delete();
    end else begin
      // Compare an accepted visit with the oldest expectation
      if (out_w.valid && out_w.ready) begin
        if (expected_visits.size() == 0) begin
          $error("unexpected visit: vertex %0d last %0d with nothing expected",
                 out_w.vertex, out_w.last);
          mismatch_count++;
        end else begin
          want = expected_visits.pop_front();
          vertex_count++;
          if (out_w.vertex !== want.vertex) begin
            $error("vertex mismatch: expected %0d, actual %0d", want.vertex, out_w.vertex);
            mismatch_count++;
          end
          if (out_w.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, out_w.last);
            mismatch_count++;
          end
        end
      end
      if (walk_mode_we_i) walk_mode_q = walk_mode_i;
      // Apply an accepted command
      if (in_w.valid && in_w.ready) begin
        case (in_w.kind)
          KIND_CLEAR: begin
            for (int r = 0; r < NV; r++) adj_rows[r] = '0;
          end
          KIND_ADD: begin
            adj_rows[in_w.from_vertex][in_w.to_vertex] = 1'b1;
          end
          KIND_START: begin
            predict_walk(in_w.from_vertex);
            walk_count++;
          end
          default: begin
          end
        endcase
      end
    end
    pending_count = expected_visits.size();
  end

endmodule : gte_checker

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gte_pkg::*;
  import gte_tb_pkg::*;

  // Cycles for a walk that leaves no visit outstanding to wind down
  localparam int SETTLE_CYCLES = 48;
  localparam int LONG_HOLD     = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic walk_mode_we;
  logic walk_mode_val;

  gte_in_if  cmd_ch ();
  gte_out_if visit_ch ();

  int  mismatch_count;
  int  pending_count;
  int  walk_count;
  int  vertex_count;
  int  cmd_count = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  rx_hold_cycles = 0;

  always #1 clk_i = ~clk_i;

  graph_traversal_engine_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (cmd_ch),
    .out_o          (visit_ch),
    .walk_mode_we_i (walk_mode_we),
    .walk_mode_i    (walk_mode_val)
  );

  gte_checker walk_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_w           (cmd_ch),
    .out_w          (visit_ch),
    .walk_mode_we_i (walk_mode_we),
    .walk_mode_i    (walk_mode_val),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .walk_count     (walk_count),
    .vertex_count   (vertex_count)
  );

  // Drop the run if it hangs
  initial begin
    #1000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold when requested
  initial begin
    visit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        visit_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
        visit_ch.ready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        visit_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        visit_ch.ready <= 1'b1;
      end else begin
        visit_ch.ready <= 1'b1;
      end
    end
  end

  // Pick any vertex the fields can name
  function automatic logic [VERTEX_W-1:0] rand_vertex();
    return VERTEX_W'($urandom_range(0, FIELD_SPAN - 1));
  endfunction

  // Offer one command, with an occasional gap first, and hold it until taken
  task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [VERTEX_W-1:0] src,
                          input logic [VERTEX_W-1:0] dst);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.kind        <= k;
    cmd_ch.from_vertex <= src;
    cmd_ch.to_vertex   <= dst;
    do @(posedge clk_i); while (!cmd_ch.ready);
    if (k != KIND_UNUSED) cmd_count++;
  endtask

  // Stop offering and wait until every predicted visit has come out
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_walk_mode(input logic m);
    drain();
    walk_mode_we  <= 1'b1;
    walk_mode_val <= m;
    @(posedge clk_i);
    walk_mode_we  <= 1'b0;
  endtask

  // Build a graph of a random shape, then walk it from a few vertices
  task automatic random_session();
    logic [VERTEX_W-1:0] perm [FIELD_SPAN];
    logic [VERTEX_W-1:0] tmp;
    logic [KIND_W-1:0]   k;
    int                  shape;
    int                  n;
    int                  j;
    shape = $urandom_range(0, 9);
    // Noise: any code, any fields
    if (shape == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        k = KIND_W'($urandom_range(0, 3));
        send_cmd(k, rand_vertex(), rand_vertex());
      end
      return;
    end
    if ($urandom_range(0, 3) != 0) send_cmd(KIND_CLEAR, rand_vertex(), rand_vertex());
    for (int i = 0; i < FIELD_SPAN; i++) perm[i] = VERTEX_W'(i);
    if (shape < 4) begin
      // Sparse edges
      n = $urandom_range(1, 10);
      repeat (n) send_cmd(KIND_ADD, rand_vertex(), rand_vertex());
    end else if (shape < 7) begin
      // Chain through shuffled vertices for long walks, plus a few extras
      for (int i = FIELD_SPAN - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      n = $urandom_range(3, FIELD_SPAN - 1);
      for (int i = 0; i < n; i++) send_cmd(KIND_ADD, perm[i], perm[i+1]);
      n = $urandom_range(0, 3);
      repeat (n) send_cmd(KIND_ADD, rand_vertex(), rand_vertex());
    end else begin
      // Dense graph
      n = $urandom_range(16, 40);
      repeat (n) send_cmd(KIND_ADD, rand_vertex(), rand_vertex());
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      if (shape >= 4 && shape < 7 && $urandom_range(0, 1) == 0)
        send_cmd(KIND_START, perm[0], rand_vertex());
      else
        send_cmd(KIND_START, rand_vertex(), rand_vertex());
    end
  endtask

  task automatic run_phase(input logic m, input int upto);
    set_walk_mode(m);
    while (cmd_count < upto) random_session();
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.kind        <= KIND_CLEAR;
    cmd_ch.from_vertex <= '0;
    cmd_ch.to_vertex   <= '0;
    walk_mode_we       <= 1'b0;
    walk_mode_val      <= MODE_DEPTH;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty graph, extreme vertices, self loop, ignored code
    set_walk_mode(MODE_DEPTH);
    send_cmd(KIND_START, 4'd9, 4'd0);
    send_cmd(KIND_ADD, 4'd0, 4'd15);
    send_cmd(KIND_ADD, 4'd15, 4'd0);
    send_cmd(KIND_ADD, 4'd0, 4'd3);
    send_cmd(KIND_ADD, 4'd3, 4'd3);
    send_cmd(KIND_ADD, 4'd3, 4'd15);
    send_cmd(KIND_ADD, 4'd15, 4'd9);
    send_cmd(KIND_UNUSED, 4'd15, 4'd15);
    send_cmd(KIND_START, 4'd0, 4'd15);
    send_cmd(KIND_START, 4'd15, 4'd0);
    set_walk_mode(MODE_BREADTH);
    send_cmd(KIND_START, 4'd0, 4'd0);
    send_cmd(KIND_START, 4'd9, 4'd15);
    send_cmd(KIND_CLEAR, 4'd15, 4'd15);
    send_cmd(KIND_START, 4'd0, 4'd0);

    // Random phases; the second opens with a long result stall
    run_phase(MODE_BREADTH, 130);
    set_walk_mode(MODE_DEPTH);
    rx_hold_cycles = LONG_HOLD;
    while (cmd_count < 230) random_session();
    set_walk_mode(MODE_BREADTH);
    while (cmd_count < 280) random_session();
    drain();
    while (cmd_count < 330) random_session();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(MODE_DEPTH, 430);
    drain();

    $display("Covered %0d commands with %0d walks and %0d visits checked,",
             cmd_count, walk_count, vertex_count);
    $display("over both walk orders, sparse, chained and dense graphs and a long stall.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule : testbench
